// File: hw/rtl/qir_pkg.sv
package qir_pkg;

  localparam int SQ_BITS      = 31;
  localparam int CORDIC_STEPS = 60;
  localparam int DIV_BITS     = 48;
  localparam int F_BITS       = DIV_BITS;
  localparam int P_BITS       = F_BITS + 8;
  // register stages from a sample entering to the scale factor leaving
  localparam int ANG_LAT      = 1 + SQ_BITS + 1 + CORDIC_STEPS + 1 + DIV_BITS;

  localparam logic signed [63:0] PI_QUARTER = 64'sh0C90FDAA22168C23;
  localparam logic signed [63:0] PI_HALF    = 64'sh1921FB54442D1846;
  localparam logic signed [31:0] ONE_Q30    = 32'sh40000000;
  localparam logic [7:0]         RATE_RESET = 8'd50;

  typedef struct packed {
    logic [4:0]         sensor_index;
    logic signed [31:0] qx;
    logic signed [31:0] qy;
    logic signed [31:0] qz;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic               undef;
  } item_t;

  typedef struct packed {
    logic [4:0]  sensor_tag;
    logic [31:0] rate_x;
    logic [31:0] rate_y;
    logic [31:0] rate_z;
    logic [31:0] accel_x;
    logic [31:0] accel_y;
    logic [31:0] accel_z;
    logic        axis_undefined;
  } result_t;

  // shift-subtract quotient of two unsigned values; elaboration only
  function automatic logic [63:0] const_quot(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    int          b;
    q = '0;
    r = '0;
    for (b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in Q60, by the truncated alternating series; elaboration only
  function automatic logic signed [63:0] step_angle(input int i);
    logic signed [63:0] sum;
    longint             term;
    int                 k;
    sum = '0;
    if (i == 0) return PI_QUARTER;
    for (k = 0; i * (2 * k + 1) <= 60; k++) begin
      term = longint'(const_quot(64'd1 << (60 - i * (2 * k + 1)), 64'(2 * k + 1)));
      if (k[0]) sum = sum - term;
      else sum = sum + term;
    end
    return sum;
  endfunction

  function automatic logic [31:0] sat_pack(input logic [63:0] mag, input logic neg);
    logic [31:0] res;
    if (neg) begin
      if (mag >= 64'h80000000) res = 32'h80000000;
      else res = 32'd0 - mag[31:0];
    end else begin
      if (mag > 64'h7FFFFFFF) res = 32'h7FFFFFFF;
      else res = mag[31:0];
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/qir_if.sv
interface qir_in_if;
  logic               valid;
  logic               ready;
  logic [4:0]         sensor_index;
  logic signed [31:0] inc_quat_w;
  logic signed [31:0] inc_quat_x;
  logic signed [31:0] inc_quat_y;
  logic signed [31:0] inc_quat_z;
  logic signed [31:0] vel_step_x;
  logic signed [31:0] vel_step_y;
  logic signed [31:0] vel_step_z;

  modport source (
    output valid, sensor_index, inc_quat_w, inc_quat_x, inc_quat_y, inc_quat_z,
           vel_step_x, vel_step_y, vel_step_z,
    input  ready
  );
  modport sink (
    input  valid, sensor_index, inc_quat_w, inc_quat_x, inc_quat_y, inc_quat_z,
           vel_step_x, vel_step_y, vel_step_z,
    output ready
  );
endinterface

interface qir_out_if;
  logic               valid;
  logic               ready;
  logic [4:0]         sensor_tag;
  logic signed [31:0] rate_x;
  logic signed [31:0] rate_y;
  logic signed [31:0] rate_z;
  logic signed [31:0] accel_x;
  logic signed [31:0] accel_y;
  logic signed [31:0] accel_z;
  logic               axis_undefined;

  modport source (
    output valid, sensor_tag, rate_x, rate_y, rate_z, accel_x, accel_y, accel_z,
           axis_undefined,
    input  ready
  );
  modport sink (
    input  valid, sensor_tag, rate_x, rate_y, rate_z, accel_x, accel_y, accel_z,
           axis_undefined,
    output ready
  );
endinterface

// File: hw/rtl/quat_increment_to_rate_unit.sv
// Orientation-increment to angular-rate converter.
// sample (sink): one inertial sample per transfer, quaternion increment in
//   Q2.30 and velocity increment in Q8.24, plus a sensor index.
// result (source): one result per sample, in order: rates in Q12.20 rad/s,
//   accelerations in Q16.16 m/s^2, echoed tag and the undefined-axis flag.
// cfg_wr_en / cfg_wr_data: update rate in Hz; write only while idle.
// Stages: 32 for the square root, 61 for the arctangent, 49 for the
// divide, then scaling, two lane stages and the output register; the
// root, arctangent and divider stages set the depth. Every stage advances
// together, taking one sample per cycle while the skid register is empty.
// When the receiver stalls, one result parks in a skid register and the
// pipeline holds until it drains; sample.ready follows that register only.
// Reset clears all valid flags and loads the update rate with 50 Hz.
module quat_increment_to_rate_unit (
  input  logic              clk,
  input  logic              rst,
  qir_in_if.sink            sample,
  qir_out_if.source         result,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data
);

  localparam int PIPE = qir_pkg::ANG_LAT + 1;

  logic [7:0]                   rate;
  logic                         en;
  logic                         vl [0:PIPE+1];
  qir_pkg::item_t               dl [0:PIPE-1];
  qir_pkg::item_t               item_in;
  logic [4:0]                   tag1;
  logic [4:0]                   tag2;
  logic                         und1;
  logic                         und2;
  logic [qir_pkg::F_BITS-1:0]   f;
  logic [qir_pkg::P_BITS-1:0]   p;
  logic [31:0]                  r_x, r_y, r_z, a_x, a_y, a_z;
  qir_pkg::result_t             pipe_res;
  qir_pkg::result_t             o_res;
  qir_pkg::result_t             s_res;
  logic                         o_valid;
  logic                         s_valid;

  assign en           = !s_valid;
  assign sample.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate <= qir_pkg::RATE_RESET;
    end else if (cfg_wr_en) begin
      rate <= cfg_wr_data;
    end
  end

  always_comb begin
    item_in.sensor_index = sample.sensor_index;
    item_in.qx           = sample.inc_quat_x;
    item_in.qy           = sample.inc_quat_y;
    item_in.qz           = sample.inc_quat_z;
    item_in.vx           = sample.vel_step_x;
    item_in.vy           = sample.vel_step_y;
    item_in.vz           = sample.vel_step_z;
    item_in.undef        = (sample.inc_quat_w >= qir_pkg::ONE_Q30) ||
                           (sample.inc_quat_w <= -qir_pkg::ONE_Q30);
  end

  qir_angle u_angle (
    .clk (clk),
    .en  (en),
    .w   (sample.inc_quat_w),
    .f   (f)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dl[0] <= item_in;
      p     <= f * rate;
    end
  end

  for (genvar k = 1; k < PIPE; k++) begin : g_dl
    always_ff @(posedge clk) begin
      if (en) dl[k] <= dl[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vl[0] <= 1'b0;
    end else if (en) begin
      vl[0] <= sample.valid;
    end
  end

  for (genvar k = 1; k < PIPE + 2; k++) begin : g_vl
    always_ff @(posedge clk) begin
      if (rst) begin
        vl[k] <= 1'b0;
      end else if (en) begin
        vl[k] <= vl[k-1];
      end
    end
  end

  qir_lane u_lane_x (
    .clk (clk), .en (en), .p (p), .axis (dl[PIPE-1].qx), .vel (dl[PIPE-1].vx),
    .rate (rate), .undef (dl[PIPE-1].undef), .rate_out (r_x), .accel_out (a_x)
  );
  qir_lane u_lane_y (
    .clk (clk), .en (en), .p (p), .axis (dl[PIPE-1].qy), .vel (dl[PIPE-1].vy),
    .rate (rate), .undef (dl[PIPE-1].undef), .rate_out (r_y), .accel_out (a_y)
  );
  qir_lane u_lane_z (
    .clk (clk), .en (en), .p (p), .axis (dl[PIPE-1].qz), .vel (dl[PIPE-1].vz),
    .rate (rate), .undef (dl[PIPE-1].undef), .rate_out (r_z), .accel_out (a_z)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      tag1 <= dl[PIPE-1].sensor_index;
      und1 <= dl[PIPE-1].undef;
      tag2 <= tag1;
      und2 <= und1;
    end
  end

  // merge the lanes into one result
  always_comb begin
    pipe_res.sensor_tag     = tag2;
    pipe_res.rate_x         = r_x;
    pipe_res.rate_y         = r_y;
    pipe_res.rate_z         = r_z;
    pipe_res.accel_x        = a_x;
    pipe_res.accel_y        = a_y;
    pipe_res.accel_z        = a_z;
    pipe_res.axis_undefined = und2;
  end

  // output register with a skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      s_valid <= 1'b0;
    end else if (!o_valid || result.ready) begin
      if (s_valid) begin
        o_valid <= 1'b1;
        s_valid <= 1'b0;
      end else begin
        o_valid <= vl[PIPE+1];
      end
    end else if (vl[PIPE+1]) begin
      s_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!o_valid || result.ready) begin
      o_res <= s_valid ? s_res : pipe_res;
    end else if (!s_valid) begin
      s_res <= pipe_res;
    end
  end

  assign result.valid          = o_valid;
  assign result.sensor_tag     = o_res.sensor_tag;
  assign result.rate_x         = o_res.rate_x;
  assign result.rate_y         = o_res.rate_y;
  assign result.rate_z         = o_res.rate_z;
  assign result.accel_x        = o_res.accel_x;
  assign result.accel_y        = o_res.accel_y;
  assign result.accel_z        = o_res.accel_z;
  assign result.axis_undefined = o_res.axis_undefined;

endmodule

// File: hw/rtl/qir_angle.sv
module qir_angle (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [31:0]          w,
  output logic [qir_pkg::F_BITS-1:0]  f
);

  localparam int SQ = qir_pkg::SQ_BITS;
  localparam int CS = qir_pkg::CORDIC_STEPS;
  localparam int DV = qir_pkg::DIV_BITS;

  logic [61:0]        sq_rem  [0:SQ];
  logic [SQ-1:0]      sq_root [0:SQ];
  logic signed [31:0] sq_w    [0:SQ];

  logic signed [63:0] cx [0:CS];
  logic signed [63:0] cy [0:CS];
  logic signed [63:0] cz [0:CS];
  logic [SQ-1:0]      cs [0:CS];

  logic [31:0]        dv_rem [0:DV];
  logic [DV-1:0]      dv_q   [0:DV];
  logic [SQ-1:0]      dv_s   [0:DV];

  logic signed [63:0] w_sq;
  logic signed [63:0] d_full;
  logic signed [63:0] theta;
  logic [63:0]        num;

  assign w_sq   = w * w;
  assign d_full = (64'sd1 <<< 60) - w_sq;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem[0]  <= d_full[61:0];
      sq_root[0] <= '0;
      sq_w[0]    <= w;
    end
  end

  // square root, one result bit per stage from the top
  for (genvar j = 0; j < SQ; j++) begin : g_sqrt
    localparam int B = SQ - 1 - j;
    logic [61:0] trial;
    assign trial = (62'(sq_root[j]) << (B + 1)) | (62'd1 << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        if (sq_rem[j] >= trial) begin
          sq_rem[j+1]  <= sq_rem[j] - trial;
          sq_root[j+1] <= sq_root[j] | (SQ'(1) << B);
        end else begin
          sq_rem[j+1]  <= sq_rem[j];
          sq_root[j+1] <= sq_root[j];
        end
        sq_w[j+1] <= sq_w[j];
      end
    end
  end

  // vectoring start: base angle rides in z
  always_ff @(posedge clk) begin
    if (en) begin
      if (!sq_w[SQ][31]) begin
        cx[0] <= 64'(sq_w[SQ]) <<< 28;
        cy[0] <= {(64 - SQ)'(0), sq_root[SQ]} << 28;
        cz[0] <= '0;
      end else begin
        cx[0] <= {(64 - SQ)'(0), sq_root[SQ]} << 28;
        cy[0] <= (-64'(sq_w[SQ])) <<< 28;
        cz[0] <= qir_pkg::PI_HALF;
      end
      cs[0] <= sq_root[SQ];
    end
  end

  for (genvar i = 0; i < CS; i++) begin : g_cordic
    localparam logic signed [63:0] ANG = qir_pkg::step_angle(i);
    logic signed [63:0] dx;
    logic signed [63:0] dy;
    assign dx = cy[i] >>> i;
    assign dy = cx[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (cy[i] > 64'sd0) begin
          cx[i+1] <= cx[i] + dx;
          cy[i+1] <= cy[i] - dy;
          cz[i+1] <= cz[i] + ANG;
        end else begin
          cx[i+1] <= cx[i] - dx;
          cy[i+1] <= cy[i] + dy;
          cz[i+1] <= cz[i] - ANG;
        end
        cs[i+1] <= cs[i];
      end
    end
  end

  // clamp a negative angle to zero, double it
  assign theta = cz[CS];
  assign num   = theta[63] ? 64'd0 : {theta[62:0], 1'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem[0] <= 32'(num[63:DV]);
      dv_q[0]   <= num[DV-1:0];
      dv_s[0]   <= cs[CS];
    end
  end

  // restoring divide: dividend bits shift out the top, quotient bits in the bottom
  for (genvar k = 0; k < DV; k++) begin : g_div
    logic [31:0] t;
    logic        ge;
    assign t  = {dv_rem[k][30:0], dv_q[k][DV-1]};
    assign ge = t >= {(32 - SQ)'(0), dv_s[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem[k+1] <= ge ? t - {(32 - SQ)'(0), dv_s[k]} : t;
        dv_q[k+1]   <= {dv_q[k][DV-2:0], ge};
        dv_s[k+1]   <= dv_s[k];
      end
    end
  end

  assign f = dv_q[DV];

endmodule

// File: hw/rtl/qir_lane.sv
module qir_lane (
  input  logic                        clk,
  input  logic                        en,
  input  logic [qir_pkg::P_BITS-1:0]  p,
  input  logic signed [31:0]          axis,
  input  logic signed [31:0]          vel,
  input  logic [7:0]                  rate,
  input  logic                        undef,
  output logic [31:0]                 rate_out,
  output logic [31:0]                 accel_out
);

  localparam int H = qir_pkg::P_BITS / 2;

  logic [31:0]      a_mag;
  logic [31:0]      v_mag;
  logic             a_neg;
  logic             v_neg;
  logic             undef1;
  logic [H+31:0]    a_lo;
  logic [H+31:0]    a_hi;
  logic [39:0]      v_prod;
  logic [H+H+31:0]  a_sum;
  logic [39:0]      v_sum;

  assign a_mag = axis[31] ? 32'(-axis) : 32'(axis);
  assign v_mag = vel[31]  ? 32'(-vel)  : 32'(vel);

  // split the wide product into two partial products
  always_ff @(posedge clk) begin
    if (en) begin
      a_lo   <= p[H-1:0] * a_mag;
      a_hi   <= p[qir_pkg::P_BITS-1:H] * a_mag;
      v_prod <= v_mag * rate;
      a_neg  <= axis[31];
      v_neg  <= vel[31];
      undef1 <= undef;
    end
  end

  assign a_sum = {a_hi, H'(0)} + {H'(0), a_lo} + ((H + H + 32)'(1) << 39);
  assign v_sum = v_prod + 40'd128;

  always_ff @(posedge clk) begin
    if (en) begin
      rate_out  <= undef1 ? 32'd0
                          : qir_pkg::sat_pack(64'(a_sum[H+H+31:40]), a_neg);
      accel_out <= qir_pkg::sat_pack(64'(v_sum[39:8]), v_neg);
    end
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int LIMIT_CYCLES = 400000;
  localparam int PIPE_DEPTH   = 146;

  typedef struct {
    logic [4:0]         idx;
    logic signed [31:0] w, x, y, z, vx, vy, vz;
  } sample_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [7:0] cfg_wr_data;

  qir_in_if  sample_ch ();
  qir_out_if result_ch ();

  quat_increment_to_rate_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .sample      (sample_ch.sink),
    .result      (result_ch.source),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  qir_pkg::result_t pending_results[$];
  logic [7:0] rate_hz;
  int send_idle_pct;
  int recv_stall_pct;
  int mismatches;
  int cycles;
  logic hold_go;
  logic hold_on;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // atan(2^-i) in Q60
  function automatic longint atan_q60(input int i);
    longint sum;
    bit [63:0] term;
    int k;
    sum = 0;
    if (i == 0) return qir_pkg::PI_QUARTER;
    for (k = 0; i * (2 * k + 1) <= 60; k++) begin
      term = (64'd1 << (60 - i * (2 * k + 1))) / (2 * k + 1);
      if (k % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    return sum;
  endfunction

  function automatic bit [63:0] int_sqrt(input bit [63:0] d);
    bit [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > d) b >>= 2;
    while (b != 0) begin
      if (d >= r + b) begin
        d = d - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] clamp32(input bit [127:0] mag, input bit neg);
    if (neg) return (mag >= 128'h80000000) ? 32'h80000000 : 32'd0 - mag[31:0];
    return (mag > 128'h7FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
  endfunction

  function automatic bit [63:0] angle_over_sine(input logic signed [31:0] w);
    bit [63:0] s;
    longint x, y, z, base, dx, dy, theta;
    int i;
    s = int_sqrt((64'd1 << 60) - 64'(longint'(w) * longint'(w)));
    if (s == 0) s = 1;
    z = 0;
    if (w >= 0) begin
      x = longint'(w) <<< 28;
      y = longint'(s << 28);
      base = 0;
    end else begin
      x = longint'(s << 28);
      y = (-longint'(w)) <<< 28;
      base = qir_pkg::PI_HALF;
    end
    for (i = 0; i < qir_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += atan_q60(i);
      end else begin
        x -= dx; y += dy; z -= atan_q60(i);
      end
    end
    theta = base + z;
    if (theta < 0) theta = 0;
    return (64'(theta) << 1) / s;
  endfunction

  function automatic logic [31:0] scaled_rate(input bit [63:0] p,
                                              input logic signed [31:0] a);
    bit [127:0] mag;
    mag = (a < 0) ? 128'(-longint'(a)) : 128'(longint'(a));
    return clamp32(((128'(p) * mag) + (128'd1 << 39)) >> 40, a < 0);
  endfunction

  function automatic logic [31:0] scaled_accel(input logic signed [31:0] v);
    bit [127:0] mag;
    mag = (v < 0) ? 128'(-longint'(v)) : 128'(longint'(v));
    return clamp32((mag * rate_hz + 128) >> 8, v < 0);
  endfunction

  function automatic qir_pkg::result_t convert_sample(input sample_t smp);
    qir_pkg::result_t r;
    bit [63:0] p;
    r.sensor_tag = smp.idx;
    if (smp.w >= qir_pkg::ONE_Q30 || smp.w <= -qir_pkg::ONE_Q30) begin
      r.rate_x = '0; r.rate_y = '0; r.rate_z = '0;
      r.axis_undefined = 1'b1;
    end else begin
      p = angle_over_sine(smp.w) * 64'(rate_hz);
      r.rate_x = scaled_rate(p, smp.x);
      r.rate_y = scaled_rate(p, smp.y);
      r.rate_z = scaled_rate(p, smp.z);
      r.axis_undefined = 1'b0;
    end
    r.accel_x = scaled_accel(smp.vx);
    r.accel_y = scaled_accel(smp.vy);
    r.accel_z = scaled_accel(smp.vz);
    return r;
  endfunction

  // long receiver hold-off, runs once when requested
  initial begin
    hold_on = 1'b0;
    wait (hold_go === 1'b1);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (400) @(posedge clk);
    hold_on <= 1'b0;
  end

  // result checker and ready driver
  always @(posedge clk) begin
    qir_pkg::result_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result tag %0d", result_ch.sensor_tag);
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          if (result_ch.sensor_tag !== want.sensor_tag || result_ch.rate_x !== want.rate_x ||
              result_ch.rate_y !== want.rate_y || result_ch.rate_z !== want.rate_z ||
              result_ch.accel_x !== want.accel_x || result_ch.accel_y !== want.accel_y ||
              result_ch.accel_z !== want.accel_z ||
              result_ch.axis_undefined !== want.axis_undefined) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch exp tag %0d r %h %h %h a %h %h %h u %b",
                       want.sensor_tag, want.rate_x, want.rate_y, want.rate_z,
                       want.accel_x, want.accel_y, want.accel_z, want.axis_undefined);
              $display("         got tag %0d r %h %h %h a %h %h %h u %b",
                       result_ch.sensor_tag, result_ch.rate_x, result_ch.rate_y,
                       result_ch.rate_z, result_ch.accel_x, result_ch.accel_y,
                       result_ch.accel_z, result_ch.axis_undefined);
            end
          end
        end
      end
      result_ch.ready <= !hold_on && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic send_sample(input sample_t smp);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid        <= 1'b1;
    sample_ch.sensor_index <= smp.idx;
    sample_ch.inc_quat_w   <= smp.w;
    sample_ch.inc_quat_x   <= smp.x;
    sample_ch.inc_quat_y   <= smp.y;
    sample_ch.inc_quat_z   <= smp.z;
    sample_ch.vel_step_x   <= smp.vx;
    sample_ch.vel_step_y   <= smp.vy;
    sample_ch.vel_step_z   <= smp.vz;
    do @(posedge clk); while (!sample_ch.ready);
    pending_results = {pending_results, convert_sample(smp)};
  endtask

  task automatic drain;
    sample_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 10) @(posedge clk);
  endtask

  task automatic set_rate(input logic [7:0] hz);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= hz;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    rate_hz = hz;
  endtask

  function automatic logic signed [31:0] pick_scalar();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $signed($urandom_range(0, 32'h7FFFFFFE)) - 32'sh3FFFFFFF;
      5: return 32'sh40000000 - $urandom_range(1, 4096);
      6: return -32'sh40000000 + $urandom_range(1, 4096);
      7: return $urandom;
      8: return $signed($urandom_range(0, 2048)) - 1024;
      default: return $urandom_range(0, 1) ? qir_pkg::ONE_Q30 : -qir_pkg::ONE_Q30;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_axis();
    case ($urandom_range(0, 3))
      0: return $signed($urandom_range(0, 65535)) - 32768;
      default: return $urandom;
    endcase
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    s.idx = 5'($urandom);
    s.w = pick_scalar();
    s.x = pick_axis(); s.y = pick_axis(); s.z = pick_axis();
    s.vx = pick_axis(); s.vy = pick_axis(); s.vz = pick_axis();
    return s;
  endfunction

  function automatic sample_t make_sample(input logic [4:0] idx,
                                          input logic signed [31:0] w,
                                          input logic signed [31:0] a,
                                          input logic signed [31:0] v);
    sample_t s;
    s.idx = idx; s.w = w;
    s.x = a; s.y = -a; s.z = a >>> 3;
    s.vx = v; s.vy = -v; s.vz = v >>> 5;
    return s;
  endfunction

  task automatic test_directed;
    send_sample(make_sample(0, 0, 32'sh00100000, 32'sh01000000));
    send_sample(make_sample(31, 32'sh3FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
    send_sample(make_sample(5, -32'sh3FFFFFFF, -32'sh80000000, -32'sh80000000));
    send_sample(make_sample(7, qir_pkg::ONE_Q30, 32'sh12345678, 32'sh00000080));
    send_sample(make_sample(8, -qir_pkg::ONE_Q30, 32'sh00000001, -32'sh00000080));
    send_sample(make_sample(9, 32'sh7FFFFFFF, -32'sh00000001, 32'sh00000001));
    send_sample(make_sample(10, -32'sh80000000, 32'sh40000000, -32'sh00000001));
    send_sample(make_sample(11, 32'sh2D413CCD, 32'sh00000000, 32'sh00000000));
    send_sample(make_sample(12, -32'sh2D413CCD, 32'sh3FFFFFFF, 32'sh000001FF));
    send_sample(make_sample(13, 32'sh00000001, 32'sh7FFFFFFF, -32'sh7FFFFFFF));
    send_sample(make_sample(14, -32'sh00000001, -32'sh7FFFFFFF, 32'sh00FFFFFF));
  endtask

  task automatic test_rate_extremes;
    set_rate(8'd255);
    test_directed();
    set_rate(8'd0);
    repeat (12) send_sample(random_sample());
    set_rate(8'd1);
    test_directed();
  endtask

  task automatic test_random(input int n, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) send_sample(random_sample());
  endtask

  task automatic test_backpressure;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_go <= 1'b1;
    repeat (500) send_sample(random_sample());
  endtask

  initial begin
    rst = 1'b1;
    cycles = 0;
    mismatches = 0;
    hold_go = 1'b0;
    rate_hz = qir_pkg::RATE_RESET;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.sensor_index = '0;
    sample_ch.inc_quat_w = '0;
    sample_ch.inc_quat_x = '0;
    sample_ch.inc_quat_y = '0;
    sample_ch.inc_quat_z = '0;
    sample_ch.vel_step_x = '0;
    sample_ch.vel_step_y = '0;
    sample_ch.vel_step_z = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_rate_extremes();
    set_rate(8'd5);
    test_random(300, 0, 0);
    set_rate(8'd150);
    test_random(300, 48, 0);
    set_rate(8'd50);
    test_random(300, 0, 48);
    set_rate(8'($urandom_range(0, 255)));
    test_random(250, 38, 38);
    drain();
    test_backpressure();
    drain();

    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/qir_pkg.sv
hw/rtl/qir_if.sv
hw/rtl/qir_angle.sv
hw/rtl/qir_lane.sv
hw/rtl/quat_increment_to_rate_unit.sv
bench/tb.sv
